/* rtl/lkvc_pkg.sv */
// ----------------------------------------------------------------------------
// lkvc_pkg: shared types and constants of the lru key/value cache
// command codes, register map and the control word broadcast to the cells
// ----------------------------------------------------------------------------
`default_nettype none

package lkvc_pkg;

	// operation codes carried on the mode field
	localparam logic MODE_GET = 1'b0;
	localparam logic MODE_PUT = 1'b1;

	// register map, index of a register in the word address space
	localparam int  REG_IDX_BITS  = 1;
	localparam logic [REG_IDX_BITS-1:0] REG_CAPACITY = 1'b0;

	// capacity register
	localparam int CAP_BITS = 5;
	localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

	// control word broadcast along the row
	typedef struct packed {
		logic step;  // a word is accepted this cycle
		logic put;   // operation is a put
		logic hit;   // key matched somewhere in the row
	} cmd_t;

endpackage

`default_nettype wire

/* rtl/lkvc_cell.sv */
// ----------------------------------------------------------------------------
// lkvc_cell: one recency slot of the cache row
// holds one entry; position in the row is its recency rank, slot 0 newest
// ----------------------------------------------------------------------------
`default_nettype none

module lkvc_cell #(
	parameter int INDEX      = 0,
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 32,
	parameter int CW         = 5
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  clear,
	input  wire lkvc_pkg::cmd_t  cmd,
	input  wire [KEY_BITS-1:0]   in_key,
	input  wire [CW-1:0]         cap_eff,
	// entry offered by the newer neighbor
	input  wire                  nb_valid,
	input  wire [KEY_BITS-1:0]   nb_key,
	input  wire [VALUE_BITS-1:0] nb_value,
	// entry held here, offered to the older neighbor
	output logic                 valid_q,
	output logic [KEY_BITS-1:0]  key_q,
	output logic [VALUE_BITS-1:0] value_q,
	// match and eviction chains
	input  wire                  seen_in,
	output logic                 seen_out,
	input  wire [VALUE_BITS-1:0] hit_val_in,
	output logic [VALUE_BITS-1:0] hit_val_out,
	input  wire                  ev_in,
	output logic                 ev_out,
	input  wire [KEY_BITS-1:0]   ev_key_in,
	output logic [KEY_BITS-1:0]  ev_key_out
);

	logic match;
	logic in_cap;
	logic last;
	logic shift;

	assign match  = valid_q && (key_q == in_key);
	assign in_cap = CW'(INDEX) < cap_eff;
	assign last   = valid_q && (CW'(INDEX + 1) == cap_eff);

	assign seen_out    = seen_in | match;
	assign hit_val_out = hit_val_in | (match ? value_q : '0);
	assign ev_out      = ev_in | last;
	assign ev_key_out  = ev_key_in | (last ? key_q : '0);

	// on a hit every slot up to the matching one moves one place older;
	// on a put miss slots move down to the first free one or the capacity edge
	always_comb begin
		if (!cmd.step) begin
			shift = 1'b0;
		end else if (cmd.hit) begin
			shift = !seen_in;
		end else begin
			shift = cmd.put && nb_valid && in_cap;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (clear) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= nb_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			key_q   <= nb_key;
			value_q <= nb_value;
		end
	end

endmodule

`default_nettype wire

/* rtl/lru_key_value_cache_top.sv */
// ----------------------------------------------------------------------------
// lru_key_value_cache_top: fully associative key/value cache, lru replacement
//
// request channel (in_valid/in_ready) carries one word: mode (0 get, 1 put),
// key and value. response channel (out_valid/out_ready) returns one word per
// request: hit, read_value (stored value on a get hit, all ones on a get miss,
// zero on a put), evicted and evicted_key.
// entries sit in a row of cells ordered by recency, slot 0 newest; a touch or
// insert moves the newer entries one slot older in the same cycle, and a put
// miss at full capacity pushes the oldest entry out of the capacity edge.
// response: registered, valid in the cycle after acceptance.
// throughput: one word per cycle while responses are taken, limited by the key
// compare and match chain rippling through the row of ENTRIES cells.
// when out_ready is low the response holds and in_ready drops until it is
// taken; a new request is accepted in the same cycle the old response leaves.
// reset: all entries invalid, capacity 16, no response pending.
// capacity register at byte address 0: any write empties the cache; values
// above ENTRIES act as ENTRIES, zero means every put evicts its own key.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_key_value_cache_top #(
	parameter int ENTRIES    = 16,
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 32
) (
	input  wire                         clk,
	input  wire                         arst_n,
	// configuration port
	input  wire                         psel,
	input  wire                         penable,
	input  wire                         pwrite,
	input  wire [2:0]                   paddr,
	input  wire [31:0]                  pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	// request channel
	input  wire                         in_valid,
	output logic                        in_ready,
	input  wire                         mode,
	input  wire signed [KEY_BITS-1:0]   key,
	input  wire signed [VALUE_BITS-1:0] value,
	// response channel
	output logic                        out_valid,
	input  wire                         out_ready,
	output logic                        hit,
	output logic signed [VALUE_BITS-1:0] read_value,
	output logic                        evicted,
	output logic signed [KEY_BITS-1:0]  evicted_key
);

	localparam int CW = $clog2(ENTRIES + 1);
	localparam int EW = (CW > lkvc_pkg::CAP_BITS) ? CW : lkvc_pkg::CAP_BITS;

	// configuration
	logic [lkvc_pkg::CAP_BITS-1:0] cap_q;
	logic                          cfg_wr;
	logic                          cap_wr;
	logic [EW-1:0]                 cap_ext;
	logic [CW-1:0]                 cap_eff;

	// row links: index 0 is the incoming entry, cell i drives index i+1
	logic [ENTRIES:0]     ent_valid;
	logic [KEY_BITS-1:0]  ent_key   [0:ENTRIES];
	logic [VALUE_BITS-1:0] ent_value [0:ENTRIES];
	logic [ENTRIES:0]     seen;
	logic [VALUE_BITS-1:0] hit_val  [0:ENTRIES];
	logic [ENTRIES:0]     ev_chain;
	logic [KEY_BITS-1:0]  ev_key   [0:ENTRIES];

	lkvc_pkg::cmd_t cmd;
	logic           accept;
	logic           is_put;
	logic           any_hit;
	logic           ev_now;

	// response register
	logic                  out_valid_q;
	logic                  hit_q;
	logic [VALUE_BITS-1:0] read_value_q;
	logic                  evicted_q;
	logic [KEY_BITS-1:0]   evicted_key_q;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign cap_wr = cfg_wr && (paddr[2] == lkvc_pkg::REG_CAPACITY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= lkvc_pkg::CAP_RESET;
		end else if (cap_wr) begin
			cap_q <= pwdata[lkvc_pkg::CAP_BITS-1:0];
		end
	end

	always_comb begin
		unique case (paddr[2])
			lkvc_pkg::REG_CAPACITY: prdata = 32'(cap_q);
			default:                prdata = '0;
		endcase
	end

	// capacity saturates at the row length
	assign cap_ext = EW'(cap_q);
	assign cap_eff = (cap_ext > EW'(ENTRIES)) ? CW'(ENTRIES) : CW'(cap_ext);

	// ---------------- request handling ----------------
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign is_put   = (mode == lkvc_pkg::MODE_PUT);
	assign any_hit  = seen[ENTRIES];

	assign cmd.step = accept;
	assign cmd.put  = is_put;
	assign cmd.hit  = any_hit;

	// the entry entering slot 0: new key, with new value on put or the hit value
	assign ent_valid[0] = 1'b1;
	assign ent_key[0]   = key;
	assign ent_value[0] = is_put ? value : hit_val[ENTRIES];

	assign seen[0]     = 1'b0;
	assign hit_val[0]  = '0;
	assign ev_chain[0] = 1'b0;
	assign ev_key[0]   = '0;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		lkvc_cell #(
			.INDEX      (i),
			.KEY_BITS   (KEY_BITS),
			.VALUE_BITS (VALUE_BITS),
			.CW         (CW)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.clear       (cap_wr),
			.cmd         (cmd),
			.in_key      (key),
			.cap_eff     (cap_eff),
			.nb_valid    (ent_valid[i]),
			.nb_key      (ent_key[i]),
			.nb_value    (ent_value[i]),
			.valid_q     (ent_valid[i+1]),
			.key_q       (ent_key[i+1]),
			.value_q     (ent_value[i+1]),
			.seen_in     (seen[i]),
			.seen_out    (seen[i+1]),
			.hit_val_in  (hit_val[i]),
			.hit_val_out (hit_val[i+1]),
			.ev_in       (ev_chain[i]),
			.ev_out      (ev_chain[i+1]),
			.ev_key_in   (ev_key[i]),
			.ev_key_out  (ev_key[i+1])
		);
	end

	// a put miss evicts when the oldest slot inside capacity is occupied,
	// or always when capacity is zero (the new key itself goes out)
	assign ev_now = is_put && !any_hit &&
		((cap_eff == '0) || ev_chain[ENTRIES]);

	// ---------------- response register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hit_q     <= any_hit;
			evicted_q <= ev_now;
			if (is_put) begin
				read_value_q <= '0;
			end else if (any_hit) begin
				read_value_q <= hit_val[ENTRIES];
			end else begin
				read_value_q <= '1;
			end
			if (!ev_now) begin
				evicted_key_q <= '0;
			end else if (cap_eff == '0) begin
				evicted_key_q <= key;
			end else begin
				evicted_key_q <= ev_key[ENTRIES];
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign hit         = hit_q;
	assign read_value  = read_value_q;
	assign evicted     = evicted_q;
	assign evicted_key = evicted_key_q;

	// ---------------- assertions ----------------
	logic [ENTRIES-1:0] vld;
	assign vld = ent_valid[ENTRIES:1];

	// occupied slots always form a prefix of the row
	a_valid_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		(ENTRIES'(vld + 1'b1) & vld) == '0)
		else $error("occupied slots not contiguous from slot 0");

	// never more entries than the capacity allows
	a_occupancy: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(vld) <= int'(cap_eff))
		else $error("occupancy exceeds capacity");

	// an accepted word always yields a response next cycle
	a_resp: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid)
		else $error("accepted word produced no response");

	// an eviction only happens on a miss
	a_ev_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(evicted && hit))
		else $error("eviction reported together with a hit");

endmodule

`default_nettype wire
